// ===== hdl/ssl_pkg.sv =====
// shared constants, widths and helper functions of the stanley steering law unit
// no dependencies; used by ssl_vec and stanley_steering_law_unit
`default_nettype none

package ssl_pkg;

  // vectoring unit widths
  localparam int VEC_IN_W     = 52;  // signed input components
  localparam int CW           = 38;  // cordic working width
  localparam int ZW           = 25;  // angle accumulator, q20
  localparam int ANG_W        = 16;  // angle result, q13
  localparam int MAG_W        = 37;  // magnitude result
  localparam int SC_W         = 7;   // signed scaling exponent
  localparam int CORDIC_STEPS = 20;
  localparam int CHUNK_W      = 13;
  localparam int CHUNKS       = 4;
  localparam int NORM_TOP     = 33;  // larger component lands in [2^33, 2^34)
  localparam int VEC_LAT      = CORDIC_STEPS + 6;

  // angle arithmetic
  localparam int WRAP_W       = 20;
  localparam int PI_Q13       = 25736;
  localparam int HALF_PI_Q13  = 12868;
  localparam int TWO_PI_Q13   = 51472;
  localparam int STEER_LIMIT  = 9994;
  localparam int PI_Q20       = 3294199;
  localparam int INV_GAIN_Q16 = 39797;

  function automatic logic signed [ZW-1:0] atan_q20(input int unsigned i);
    logic signed [ZW-1:0] v;
    case (i)
      0:       v = ZW'(823550);
      1:       v = ZW'(486170);
      2:       v = ZW'(256879);
      3:       v = ZW'(130396);
      4:       v = ZW'(65451);
      5:       v = ZW'(32757);
      6:       v = ZW'(16383);
      7:       v = ZW'(8192);
      8:       v = ZW'(4096);
      9:       v = ZW'(2048);
      10:      v = ZW'(1024);
      11:      v = ZW'(512);
      12:      v = ZW'(256);
      13:      v = ZW'(128);
      14:      v = ZW'(64);
      15:      v = ZW'(32);
      16:      v = ZW'(16);
      17:      v = ZW'(8);
      18:      v = ZW'(4);
      19:      v = ZW'(2);
      default: v = '0;
    endcase
    return v;
  endfunction

  // single wrap into [-pi, pi]
  function automatic logic signed [WRAP_W-1:0] wrap_once(input logic signed [WRAP_W-1:0] a);
    logic signed [WRAP_W-1:0] r;
    r = a;
    if (r > WRAP_W'(PI_Q13)) r = r - WRAP_W'(TWO_PI_Q13);
    if (r < -WRAP_W'(PI_Q13)) r = r + WRAP_W'(TWO_PI_Q13);
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/ssl_vec.sv =====
// pipelined vectoring cordic: atan2, magnitude and scaling exponent of a vector
// depends on ssl_pkg
`default_nettype none

module ssl_vec import ssl_pkg::*; (
  input  wire                        clk_i,
  input  wire                        en_i,
  input  wire logic signed [VEC_IN_W-1:0] x_i,
  input  wire logic signed [VEC_IN_W-1:0] y_i,
  output logic signed [ANG_W-1:0]    angle_o,
  output logic        [MAG_W-1:0]    mag_o,
  output logic signed [SC_W-1:0]     scale_o
);

  // stage 1: magnitudes
  logic signed [VEC_IN_W-1:0] s1_x_q, s1_y_q;
  logic        [VEC_IN_W-1:0] s1_mx_q, ax_d, ay_d;
  logic                       s1_zero_q;

  always_comb begin
    ax_d = x_i[VEC_IN_W-1] ? VEC_IN_W'(-x_i) : VEC_IN_W'(x_i);
    ay_d = y_i[VEC_IN_W-1] ? VEC_IN_W'(-y_i) : VEC_IN_W'(y_i);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_x_q    <= x_i;
      s1_y_q    <= y_i;
      s1_mx_q   <= (ax_d > ay_d) ? ax_d : ay_d;
      s1_zero_q <= (x_i == '0) && (y_i == '0);
    end
  end

  // stage 2: leading one per chunk
  logic signed [VEC_IN_W-1:0] s2_x_q, s2_y_q;
  logic        [CHUNKS-1:0]   s2_nz_q, nz_d;
  logic        [3:0]          s2_pos_q [CHUNKS];
  logic        [3:0]          pos_d [CHUNKS];
  logic                       s2_zero_q;

  always_comb begin
    for (int c = 0; c < CHUNKS; c++) begin
      nz_d[c]  = 1'b0;
      pos_d[c] = '0;
      for (int j = 0; j < CHUNK_W; j++) begin
        if (s1_mx_q[c*CHUNK_W + j]) begin
          nz_d[c]  = 1'b1;
          pos_d[c] = 4'(j);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s2_x_q    <= s1_x_q;
      s2_y_q    <= s1_y_q;
      s2_nz_q   <= nz_d;
      s2_pos_q  <= pos_d;
      s2_zero_q <= s1_zero_q;
    end
  end

  // stage 3: scaling exponent
  logic signed [VEC_IN_W-1:0] s3_x_q, s3_y_q;
  logic signed [SC_W-1:0]     s3_s_q;
  logic                       s3_zero_q;
  logic        [5:0]          lead_d;

  always_comb begin
    lead_d = '0;
    for (int c = 0; c < CHUNKS; c++) begin
      if (s2_nz_q[c]) lead_d = 6'(c*CHUNK_W) + 6'(s2_pos_q[c]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s3_x_q    <= s2_x_q;
      s3_y_q    <= s2_y_q;
      s3_s_q    <= SC_W'(NORM_TOP) - SC_W'(lead_d);
      s3_zero_q <= s2_zero_q;
    end
  end

  // stage 4: scale by a power of two, right shifts round down
  logic signed [CW-1:0]       s4_x_q, s4_y_q;
  logic signed [SC_W-1:0]     s4_s_q;
  logic                       s4_zero_q;
  logic signed [VEC_IN_W-1:0] shx_d, shy_d;
  logic        [5:0]          lsh_d, rsh_d;

  always_comb begin
    lsh_d = s3_s_q[5:0];
    rsh_d = 6'(-s3_s_q);
    if (s3_s_q[SC_W-1]) begin
      shx_d = s3_x_q >>> rsh_d;
      shy_d = s3_y_q >>> rsh_d;
    end else begin
      shx_d = s3_x_q <<< lsh_d;
      shy_d = s3_y_q <<< lsh_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s4_x_q    <= CW'(shx_d);
      s4_y_q    <= CW'(shy_d);
      s4_s_q    <= s3_s_q;
      s4_zero_q <= s3_zero_q;
    end
  end

  // cordic chain, entry 0 holds the half-plane pre-rotation
  logic signed [CW-1:0]   cx_q [CORDIC_STEPS+1];
  logic signed [CW-1:0]   cy_q [CORDIC_STEPS+1];
  logic signed [ZW-1:0]   cz_q [CORDIC_STEPS+1];
  logic signed [SC_W-1:0] cs_q [CORDIC_STEPS+1];
  logic                   cn_q [CORDIC_STEPS+1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (s4_x_q[CW-1]) begin
        cx_q[0] <= -s4_x_q;
        cy_q[0] <= -s4_y_q;
        cz_q[0] <= s4_y_q[CW-1] ? -ZW'(PI_Q20) : ZW'(PI_Q20);
      end else begin
        cx_q[0] <= s4_x_q;
        cy_q[0] <= s4_y_q;
        cz_q[0] <= '0;
      end
      cs_q[0] <= s4_s_q;
      cn_q[0] <= s4_zero_q;
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    logic signed [CW-1:0] xs, ys;
    assign xs = cx_q[i] >>> i;
    assign ys = cy_q[i] >>> i;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (cy_q[i] > 0) begin
          cx_q[i+1] <= cx_q[i] + ys;
          cy_q[i+1] <= cy_q[i] - xs;
          cz_q[i+1] <= cz_q[i] + atan_q20(i);
        end else begin
          cx_q[i+1] <= cx_q[i] - ys;
          cy_q[i+1] <= cy_q[i] + xs;
          cz_q[i+1] <= cz_q[i] - atan_q20(i);
        end
        cs_q[i+1] <= cs_q[i];
        cn_q[i+1] <= cn_q[i];
      end
    end
  end

  // result stage: round q20 to q13, zero vector forced to zero
  logic signed [ZW-1:0] zr_d;
  logic signed [CW-1:0] xf_d;

  assign zr_d = (cz_q[CORDIC_STEPS] + ZW'(64)) >>> 7;
  assign xf_d = cx_q[CORDIC_STEPS];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (cn_q[CORDIC_STEPS]) begin
        angle_o <= '0;
        mag_o   <= '0;
        scale_o <= '0;
      end else begin
        angle_o <= ANG_W'(zr_d);
        mag_o   <= (xf_d > 0) ? xf_d[MAG_W-1:0] : '0;
        scale_o <= cs_q[CORDIC_STEPS];
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/stanley_steering_law_unit.sv =====
// stanley steering law: pose and speed in, clamped steering angle out
// depends on ssl_pkg and ssl_vec
`default_nettype none

// channel   direction  handshake               payload
// s_axis    in         s_axis_tvalid/tready    pos_x, pos_y, heading, velocity
// m_axis    out        m_axis_tvalid/tready    steer_angle
// cfg       in         cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// one request per cycle while the skid register is empty; the path runs through two cordic
// vectoring pipelines in series
// (path and bearing side by side, then the atan term)
// the datapath up to the tail register advances on one enable; a skid register behind the output
// register takes the item in flight when the sink stalls, then the enable drops
// reset clears valid bits and config registers only; cfg is always ready

module stanley_steering_law_unit import ssl_pkg::*; (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [95:0] s_axis_tdata,   // pos_x[31:0], pos_y[63:32], heading[79:64],
                                      // velocity[95:80]
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [15:0] m_axis_tdata,   // steer_angle[14:0], zero pad[15]
  input  wire         cfg_valid_i,
  output logic        cfg_ready_o,
  input  wire  [2:0]  cfg_index_i,
  input  wire  [31:0] cfg_data_i
);

  typedef enum logic [2:0] {
    REG_START_X    = 3'd0,
    REG_START_Y    = 3'd1,
    REG_END_X      = 3'd2,
    REG_END_Y      = 3'd3,
    REG_CROSS_GAIN = 3'd4,
    REG_SOFT_SPEED = 3'd5
  } cfg_reg_e;

  // configuration registers
  logic signed [31:0] start_x_q, start_y_q, end_x_q, end_y_q;
  logic        [15:0] cross_gain_q, soft_speed_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_x_q    <= '0;
      start_y_q    <= '0;
      end_x_q      <= '0;
      end_y_q      <= '0;
      cross_gain_q <= 16'd256;
      soft_speed_q <= 16'd256;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_START_X:    start_x_q    <= cfg_data_i;
        REG_START_Y:    start_y_q    <= cfg_data_i;
        REG_END_X:      end_x_q      <= cfg_data_i;
        REG_END_Y:      end_y_q      <= cfg_data_i;
        REG_CROSS_GAIN: cross_gain_q <= cfg_data_i[15:0];
        REG_SOFT_SPEED: soft_speed_q <= cfg_data_i[15:0];
        default: ;  // unknown index, write dropped
      endcase
    end
  end

  // pipeline enable: frozen only while the skid register is occupied
  logic skid_valid_q;
  logic en;
  assign en            = !skid_valid_q;
  assign s_axis_tready = en;

  // s0: input register
  logic               s0_valid_q;
  logic signed [31:0] s0_px_q, s0_py_q;
  logic signed [15:0] s0_head_q;
  logic        [15:0] s0_vel_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else if (en) begin
      s0_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_px_q   <= s_axis_tdata[31:0];
      s0_py_q   <= s_axis_tdata[63:32];
      s0_head_q <= s_axis_tdata[79:64];
      s0_vel_q  <= s_axis_tdata[95:80];
    end
  end

  // s1: differences to the start point
  logic               s1_valid_q;
  logic signed [32:0] s1_dpx_q, s1_dpy_q, s1_dex_q, s1_dey_q;
  logic signed [15:0] s1_head_q;
  logic        [15:0] s1_vel_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q <= s0_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_dpx_q  <= 33'(s0_px_q) - 33'(start_x_q);
      s1_dpy_q  <= 33'(s0_py_q) - 33'(start_y_q);
      s1_dex_q  <= 33'(end_x_q) - 33'(start_x_q);
      s1_dey_q  <= 33'(end_y_q) - 33'(start_y_q);
      s1_head_q <= s0_head_q;
      s1_vel_q  <= s0_vel_q;
    end
  end

  // path heading and bearing of the vehicle from the start point
  logic signed [ANG_W-1:0] path_ang, bear_ang, path_ang_unused_mag_guard;
  logic        [MAG_W-1:0] path_mag, bear_mag;
  logic signed [SC_W-1:0]  path_sc, bear_sc;

  ssl_vec u_vec_path (
    .clk_i   (clk_i),
    .en_i    (en),
    .x_i     (VEC_IN_W'(s1_dex_q)),
    .y_i     (VEC_IN_W'(s1_dey_q)),
    .angle_o (path_ang),
    .mag_o   (path_mag),
    .scale_o (path_sc)
  );

  ssl_vec u_vec_bear (
    .clk_i   (clk_i),
    .en_i    (en),
    .x_i     (VEC_IN_W'(s1_dpx_q)),
    .y_i     (VEC_IN_W'(s1_dpy_q)),
    .angle_o (bear_ang),
    .mag_o   (bear_mag),
    .scale_o (bear_sc)
  );

  // path magnitude and scale are not needed; fold them into a harmless guard
  assign path_ang_unused_mag_guard = (path_mag == '0 && path_sc == '0) ? '0 : path_ang;

  // side data travelling alongside the first cordic pair
  logic               dl_valid_q [VEC_LAT];
  logic signed [15:0] dl_head_q  [VEC_LAT];
  logic        [15:0] dl_vel_q   [VEC_LAT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < VEC_LAT; k++) dl_valid_q[k] <= 1'b0;
    end else if (en) begin
      dl_valid_q[0] <= s1_valid_q;
      for (int k = 1; k < VEC_LAT; k++) dl_valid_q[k] <= dl_valid_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dl_head_q[0] <= s1_head_q;
      dl_vel_q[0]  <= s1_vel_q;
      for (int k = 1; k < VEC_LAT; k++) begin
        dl_head_q[k] <= dl_head_q[k-1];
        dl_vel_q[k]  <= dl_vel_q[k-1];
      end
    end
  end

  // p1: heading error, side of the path, distance scaled by 1/K
  logic                     p1_valid_q;
  logic signed [WRAP_W-1:0] p1_herr_q, herr_d, side_d;
  logic                     p1_neg_q;
  logic        [MAG_W+15:0] p1_prod_q;
  logic signed [SC_W-1:0]   p1_sc_q;
  logic        [15:0]       p1_vel_q;

  // a zero path vector gives angle zero either way, so the guard is exact
  assign herr_d = wrap_once(WRAP_W'(path_ang_unused_mag_guard)
                            - WRAP_W'(dl_head_q[VEC_LAT-1]));
  assign side_d = wrap_once(WRAP_W'(path_ang_unused_mag_guard) - WRAP_W'(bear_ang));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_valid_q <= 1'b0;
    end else if (en) begin
      p1_valid_q <= dl_valid_q[VEC_LAT-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_herr_q <= herr_d;
      p1_neg_q  <= (side_d <= 0);
      p1_prod_q <= (MAG_W+16)'(bear_mag) * (MAG_W+16)'(INV_GAIN_Q16);
      p1_sc_q   <= bear_sc;
      p1_vel_q  <= dl_vel_q[VEC_LAT-1];
    end
  end

  // p2: undo the scaling with round half up, apply the side sign
  logic                     p2_valid_q;
  logic signed [WRAP_W-1:0] p2_herr_q;
  logic signed [34:0]       p2_ct_q, ct_d;
  logic        [15:0]       p2_vel_q;
  logic signed [SC_W-1:0]   sh7_d;
  logic        [5:0]        sh_d;
  logic        [MAG_W+16:0] rnd_d, rsum_d, rsh_d;

  always_comb begin
    sh7_d  = p1_sc_q + SC_W'(16);
    sh_d   = sh7_d[5:0];
    rnd_d  = (MAG_W+17)'(1) << (sh_d - 6'd1);
    rsum_d = (MAG_W+17)'(p1_prod_q) + rnd_d;
    rsh_d  = rsum_d >> sh_d;
    ct_d   = p1_neg_q ? -$signed({1'b0, rsh_d[33:0]}) : $signed({1'b0, rsh_d[33:0]});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p2_valid_q <= 1'b0;
    end else if (en) begin
      p2_valid_q <= p1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p2_herr_q <= p1_herr_q;
      p2_ct_q   <= ct_d;
      p2_vel_q  <= p1_vel_q;
    end
  end

  // p3: numerator and denominator of the crosstrack term
  logic                      p3_valid_q;
  logic signed [WRAP_W-1:0]  p3_herr_q;
  logic signed [VEC_IN_W-1:0] p3_num_q, p3_den_q;
  logic                      p3_nz_q, p3_dz_q, p3_neg_q;
  logic        [16:0]        den_sum_d;

  assign den_sum_d = 17'(soft_speed_q) + 17'(p2_vel_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p3_valid_q <= 1'b0;
    end else if (en) begin
      p3_valid_q <= p2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p3_herr_q <= p2_herr_q;
      p3_num_q  <= VEC_IN_W'($signed({1'b0, cross_gain_q})) * VEC_IN_W'(p2_ct_q);
      p3_den_q  <= VEC_IN_W'({den_sum_d, 16'd0});
      p3_nz_q   <= (cross_gain_q == '0) || (p2_ct_q == '0);
      p3_dz_q   <= (den_sum_d == '0);
      p3_neg_q  <= p2_ct_q[34];
    end
  end

  // atan of the crosstrack term
  logic signed [ANG_W-1:0] term_ang;
  logic        [MAG_W-1:0] term_mag;
  logic signed [SC_W-1:0]  term_sc;

  ssl_vec u_vec_term (
    .clk_i   (clk_i),
    .en_i    (en),
    .x_i     (p3_den_q),
    .y_i     (p3_num_q),
    .angle_o (term_ang),
    .mag_o   (term_mag),
    .scale_o (term_sc)
  );

  logic                     dm_valid_q [VEC_LAT];
  logic signed [WRAP_W-1:0] dm_herr_q  [VEC_LAT];
  logic                     dm_nz_q    [VEC_LAT];
  logic                     dm_dz_q    [VEC_LAT];
  logic                     dm_neg_q   [VEC_LAT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < VEC_LAT; k++) dm_valid_q[k] <= 1'b0;
    end else if (en) begin
      dm_valid_q[0] <= p3_valid_q;
      for (int k = 1; k < VEC_LAT; k++) dm_valid_q[k] <= dm_valid_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dm_herr_q[0] <= p3_herr_q;
      dm_nz_q[0]   <= p3_nz_q;
      dm_dz_q[0]   <= p3_dz_q;
      dm_neg_q[0]  <= p3_neg_q;
      for (int k = 1; k < VEC_LAT; k++) begin
        dm_herr_q[k] <= dm_herr_q[k-1];
        dm_nz_q[k]   <= dm_nz_q[k-1];
        dm_dz_q[k]   <= dm_dz_q[k-1];
        dm_neg_q[k]  <= dm_neg_q[k-1];
      end
    end
  end

  // p4: special cases, sum, wrap and clamp into the tail register
  logic                     tail_valid_q;
  logic signed [14:0]       tail_steer_q;
  logic signed [WRAP_W-1:0] term_d, delta_d, clamp_d;

  always_comb begin
    if (dm_nz_q[VEC_LAT-1]) begin
      term_d = '0;
    end else if (dm_dz_q[VEC_LAT-1]) begin
      term_d = dm_neg_q[VEC_LAT-1] ? -WRAP_W'(HALF_PI_Q13) : WRAP_W'(HALF_PI_Q13);
    end else begin
      // magnitude and scale of the term vector only matter when it is zero
      term_d = (term_mag == '0 && term_sc == '0) ? '0 : WRAP_W'(term_ang);
    end
    delta_d = wrap_once(dm_herr_q[VEC_LAT-1] + term_d);
    clamp_d = delta_d;
    if (delta_d > WRAP_W'(STEER_LIMIT)) clamp_d = WRAP_W'(STEER_LIMIT);
    if (delta_d < -WRAP_W'(STEER_LIMIT)) clamp_d = -WRAP_W'(STEER_LIMIT);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tail_valid_q <= 1'b0;
    end else if (en) begin
      tail_valid_q <= dm_valid_q[VEC_LAT-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      tail_steer_q <= clamp_d[14:0];
    end
  end

  // output register with skid
  logic              out_valid_q;
  logic signed [14:0] out_steer_q, skid_steer_q;
  logic              tail_out;

  assign tail_out = en && tail_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || m_axis_tready) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= tail_out;
      end
    end else if (tail_out) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || m_axis_tready) begin
      out_steer_q <= skid_valid_q ? skid_steer_q : tail_steer_q;
    end else if (tail_out) begin
      skid_steer_q <= tail_steer_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_steer_q};

endmodule

`default_nettype wire
